/* hdl/ccent_pkg.sv */
package ccent_pkg;

  // Coordinate format
  localparam int COORD_FRAC_BITS = 8;
  localparam int SCALE_FRAC_BITS = 24;
  localparam int SCALE_SHIFT     = SCALE_FRAC_BITS - COORD_FRAC_BITS;
  localparam int COORD_W         = 21;
  localparam logic signed [COORD_W-1:0] COORD_MAX = (COORD_W)'((1 << (COORD_W - 1)) - 1);

  // Raw input, scale and product widths
  localparam int RAW_W   = 32;
  localparam int SCALE_W = 32;
  localparam int PROD_W  = RAW_W + SCALE_W;
  localparam int SHR_W   = PROD_W - SCALE_SHIFT;

  // Accumulator and divider widths
  localparam int ACC_W   = 64;
  localparam int DSR_W   = ACC_W + 2;
  localparam int DCNT_W  = $clog2(ACC_W);

  // Configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    REG_SCALE_X  = 2'd0,
    REG_SCALE_Y  = 2'd1,
    REG_ORIGIN_X = 2'd2,
    REG_ORIGIN_Y = 2'd3
  } reg_idx_t;

  // One transformed point word passed from front to back
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      line_end;
    logic                      sample_end;
  } point_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

/* hdl/cut_path_transform_centroid.sv */
// Path point transform and shoelace centroid. Each accepted word is a raw
// point; it is scaled by the Q8.24 factor, floor-shifted to Q.8 mm, offset
// by the origin and clamped to +/-1048575, and yields exactly one result word.
// The front holds one point in its scale multiply stage and places and clamps
// it straight into a two-word queue, so it takes a point every cycle while the
// queue has room. The back works through each point in steps: cross products,
// cross term, moment terms, the saturating sums and the result handoff, and
// takes no new point until that handoff is done; a sample-end point adds a
// setup step, a bit-serial divide (both axes in parallel) and a step to pick
// up the quotients, or only the setup step when the area is zero. Registers at
// byte addresses 0, 4, 8, 12: scale_x, scale_y, origin_x, origin_y; write
// them only while the block is idle.
module cut_path_transform_centroid (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic [ccent_pkg::CFG_ADDR_W-1:0]         paddr,
  input  logic [ccent_pkg::CFG_DATA_W-1:0]         pwdata,
  output logic [ccent_pkg::CFG_DATA_W-1:0]         prdata,
  output logic                                     pready,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic signed [ccent_pkg::RAW_W-1:0]       in_raw_x,
  input  logic signed [ccent_pkg::RAW_W-1:0]       in_raw_y,
  input  logic                                     in_line_end,
  input  logic                                     in_sample_end,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [ccent_pkg::COORD_W-1:0]     out_point_x_mm,
  output logic signed [ccent_pkg::COORD_W-1:0]     out_point_y_mm,
  output logic                                     out_centroid_valid,
  output logic signed [ccent_pkg::ACC_W-1:0]       out_centroid_x,
  output logic signed [ccent_pkg::ACC_W-1:0]       out_centroid_y,
  output logic signed [ccent_pkg::ACC_W-1:0]       out_area_doubled,
  output logic                                     out_degenerate,
  output logic                                     out_overflowed
);

  logic [ccent_pkg::SCALE_W-1:0]        scale_x_r, scale_y_r;
  logic signed [ccent_pkg::COORD_W-1:0] origin_x_r, origin_y_r;
  ccent_pkg::reg_idx_t                  idx;
  logic                                 wr_en;
  ccent_pkg::q_stat_t                   q_stat;
  logic                                 push, pop;
  ccent_pkg::point_t                    push_data, pop_data;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = ccent_pkg::reg_idx_t'(paddr[3:2]);

  // Register read
  always_comb begin
    unique case (idx)
      ccent_pkg::REG_SCALE_X:  prdata = scale_x_r;
      ccent_pkg::REG_SCALE_Y:  prdata = scale_y_r;
      ccent_pkg::REG_ORIGIN_X: prdata = ccent_pkg::CFG_DATA_W'(origin_x_r);
      ccent_pkg::REG_ORIGIN_Y: prdata = ccent_pkg::CFG_DATA_W'(origin_y_r);
      default:                 prdata = '0;
    endcase
  end

  // Register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_x_r  <= ccent_pkg::SCALE_W'(1 << ccent_pkg::SCALE_FRAC_BITS);
      scale_y_r  <= ccent_pkg::SCALE_W'(1 << ccent_pkg::SCALE_FRAC_BITS);
      origin_x_r <= '0;
      origin_y_r <= '0;
    end else if (wr_en) begin
      unique case (idx)
        ccent_pkg::REG_SCALE_X:  scale_x_r  <= pwdata;
        ccent_pkg::REG_SCALE_Y:  scale_y_r  <= pwdata;
        ccent_pkg::REG_ORIGIN_X: origin_x_r <= pwdata[ccent_pkg::COORD_W-1:0];
        ccent_pkg::REG_ORIGIN_Y: origin_y_r <= pwdata[ccent_pkg::COORD_W-1:0];
        default: ;
      endcase
    end
  end

  ccent_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_raw_x      (in_raw_x),
    .in_raw_y      (in_raw_y),
    .in_line_end   (in_line_end),
    .in_sample_end (in_sample_end),
    .scale_x       (scale_x_r),
    .scale_y       (scale_y_r),
    .origin_x      (origin_x_r),
    .origin_y      (origin_y_r),
    .q_stat        (q_stat),
    .push          (push),
    .push_data     (push_data)
  );

  ccent_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  ccent_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_stat             (q_stat),
    .pop_data           (pop_data),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_point_x_mm     (out_point_x_mm),
    .out_point_y_mm     (out_point_y_mm),
    .out_centroid_valid (out_centroid_valid),
    .out_centroid_x     (out_centroid_x),
    .out_centroid_y     (out_centroid_y),
    .out_area_doubled   (out_area_doubled),
    .out_degenerate     (out_degenerate),
    .out_overflowed     (out_overflowed)
  );

endmodule

/* hdl/ccent_fifo.sv */
module ccent_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ccent_pkg::point_t push_data,
  input  logic              pop,
  output ccent_pkg::point_t pop_data,
  output ccent_pkg::q_stat_t stat
);

  ccent_pkg::point_t mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  assign pop_data   = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);

  // Store the word
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      if (push && !pop)      cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end

endmodule

/* hdl/ccent_front.sv */
module ccent_front (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [ccent_pkg::RAW_W-1:0]     in_raw_x,
  input  logic signed [ccent_pkg::RAW_W-1:0]     in_raw_y,
  input  logic                                   in_line_end,
  input  logic                                   in_sample_end,
  input  logic [ccent_pkg::SCALE_W-1:0]          scale_x,
  input  logic [ccent_pkg::SCALE_W-1:0]          scale_y,
  input  logic signed [ccent_pkg::COORD_W-1:0]   origin_x,
  input  logic signed [ccent_pkg::COORD_W-1:0]   origin_y,
  input  ccent_pkg::q_stat_t                     q_stat,
  output logic                                   push,
  output ccent_pkg::point_t                      push_data
);

  logic                                    busy_r;
  logic signed [ccent_pkg::PROD_W:0]       prod_x_r, prod_y_r;
  logic                                    le_r, se_r;
  logic signed [ccent_pkg::PROD_W:0]       prod_x_nxt, prod_y_nxt;

  // Scale product: signed raw times unsigned scale
  assign prod_x_nxt = $signed(in_raw_x) * $signed({1'b0, scale_x});
  assign prod_y_nxt = $signed(in_raw_y) * $signed({1'b0, scale_y});

  function automatic logic signed [ccent_pkg::COORD_W-1:0] place(
    input logic signed [ccent_pkg::PROD_W:0]     prod,
    input logic signed [ccent_pkg::COORD_W-1:0]  org
  );
    logic signed [ccent_pkg::SHR_W-1:0] sh;
    logic signed [ccent_pkg::SHR_W:0]   q;
    sh = prod[ccent_pkg::PROD_W-1:ccent_pkg::SCALE_SHIFT];
    q  = (ccent_pkg::SHR_W + 1)'(sh) + (ccent_pkg::SHR_W + 1)'(org);
    if (q > (ccent_pkg::SHR_W + 1)'(ccent_pkg::COORD_MAX)) begin
      return ccent_pkg::COORD_MAX;
    end else if (q < -((ccent_pkg::SHR_W + 1)'(ccent_pkg::COORD_MAX))) begin
      return -ccent_pkg::COORD_MAX;
    end
    return q[ccent_pkg::COORD_W-1:0];
  endfunction

  // Floor shift, add origin, clamp
  assign push           = busy_r && !q_stat.full;
  assign push_data.x    = place(prod_x_r, origin_x);
  assign push_data.y    = place(prod_y_r, origin_y);
  assign push_data.line_end   = le_r;
  assign push_data.sample_end = se_r;
  assign in_ready       = !busy_r || push;

  // Hold the product stage
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      prod_x_r <= prod_x_nxt;
      prod_y_r <= prod_y_nxt;
      le_r     <= in_line_end;
      se_r     <= in_sample_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      busy_r <= 1'b1;
    end else if (push) begin
      busy_r <= 1'b0;
    end
  end

endmodule

/* hdl/ccent_div.sv */
module ccent_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [ccent_pkg::ACC_W-1:0]       dividend,
  input  logic [ccent_pkg::DSR_W-1:0]       divisor,
  output logic                              busy,
  output logic [ccent_pkg::ACC_W-1:0]       quotient
);

  logic                              busy_r;
  logic [ccent_pkg::DCNT_W-1:0]      cnt_r;
  logic [ccent_pkg::DSR_W-1:0]       dsr_r, rem_r;
  logic [ccent_pkg::ACC_W-1:0]       quo_r;
  logic [ccent_pkg::DSR_W:0]         rem_sh;
  logic                              ge;

  // One quotient bit per cycle, restoring
  assign rem_sh   = {rem_r, quo_r[ccent_pkg::ACC_W-1]};
  assign ge       = (rem_sh >= {1'b0, dsr_r});
  assign busy     = busy_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (start) begin
      dsr_r <= divisor;
      rem_r <= '0;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= ge ? ccent_pkg::DSR_W'(rem_sh - {1'b0, dsr_r})
                  : rem_sh[ccent_pkg::DSR_W-1:0];
      quo_r <= {quo_r[ccent_pkg::ACC_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == '1) busy_r <= 1'b0;
    end
  end

endmodule

/* hdl/ccent_back.sv */
module ccent_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  ccent_pkg::q_stat_t                   q_stat,
  input  ccent_pkg::point_t                    pop_data,
  output logic                                 pop,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [ccent_pkg::COORD_W-1:0] out_point_x_mm,
  output logic signed [ccent_pkg::COORD_W-1:0] out_point_y_mm,
  output logic                                 out_centroid_valid,
  output logic signed [ccent_pkg::ACC_W-1:0]   out_centroid_x,
  output logic signed [ccent_pkg::ACC_W-1:0]   out_centroid_y,
  output logic signed [ccent_pkg::ACC_W-1:0]   out_area_doubled,
  output logic                                 out_degenerate,
  output logic                                 out_overflowed
);

  localparam int CW = ccent_pkg::COORD_W;
  localparam int AW = ccent_pkg::ACC_W;

  typedef enum logic [2:0] {
    S_IDLE, S_CROSS, S_MOM, S_ACC, S_DSET, S_DIV, S_OUT
  } state_t;

  state_t state_r;

  // Path state
  logic signed [CW-1:0]   prev_x_r, prev_y_r, cur_x_r, cur_y_r;
  logic                   have_prev_r, le_r, se_r;
  logic signed [AW-1:0]   area_r, mx_r, my_r;
  logic                   ovf_r;

  // Product pipeline
  logic signed [2*CW-1:0] p1_r, p2_r;
  logic signed [CW:0]     sx_r, sy_r;
  logic signed [2*CW:0]   c_r;
  logic signed [AW-1:0]   tx_r, ty_r;
  logic signed [AW+CW+1:0] tx_full, ty_full;

  // Divider control
  logic                   neg_x_r, neg_y_r;
  logic                   div_start, busy_x, busy_y;
  logic [AW-1:0]          q_x, q_y;
  logic [AW-1:0]          area_mag, mx_mag, my_mag;
  logic [ccent_pkg::DSR_W-1:0] dsr;

  // Output word
  logic                   ov_r, o_cv_r, o_deg_r, o_ovf_r;
  logic signed [CW-1:0]   o_x_r, o_y_r;
  logic signed [AW-1:0]   o_cx_r, o_cy_r, o_area_r;

  logic signed [AW-1:0]   c_ext, area_nxt, mx_nxt, my_nxt;
  logic                   ovf_a, ovf_mx, ovf_my;

  function automatic logic [AW:0] sat_add(
    input logic signed [AW-1:0] a,
    input logic signed [AW-1:0] b
  );
    logic signed [AW-1:0] r;
    logic                 o;
    r = a + b;
    o = (a[AW-1] == b[AW-1]) && (r[AW-1] != a[AW-1]);
    if (o) r = a[AW-1] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
    return {o, r};
  endfunction

  function automatic logic [AW-1:0] magn(input logic signed [AW-1:0] v);
    return v[AW-1] ? AW'(-v) : v;
  endfunction

  assign tx_full = c_r * sx_r;
  assign ty_full = c_r * sy_r;
  assign c_ext   = AW'(c_r);
  assign {ovf_a,  area_nxt} = sat_add(area_r, c_ext);
  assign {ovf_mx, mx_nxt}   = sat_add(mx_r, tx_r);
  assign {ovf_my, my_nxt}   = sat_add(my_r, ty_r);

  assign area_mag  = magn(area_r);
  assign mx_mag    = magn(mx_r);
  assign my_mag    = magn(my_r);
  assign dsr       = ccent_pkg::DSR_W'(area_mag) + {area_mag, 1'b0};
  assign div_start = (state_r == S_DSET) && (area_r != '0);
  assign pop       = (state_r == S_IDLE) && !q_stat.empty;

  ccent_div u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mx_mag),
    .divisor  (dsr),
    .busy     (busy_x),
    .quotient (q_x)
  );

  ccent_div u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (my_mag),
    .divisor  (dsr),
    .busy     (busy_y),
    .quotient (q_y)
  );

  assign out_valid          = ov_r;
  assign out_point_x_mm     = o_x_r;
  assign out_point_y_mm     = o_y_r;
  assign out_centroid_valid = o_cv_r;
  assign out_centroid_x     = o_cx_r;
  assign out_centroid_y     = o_cy_r;
  assign out_area_doubled   = o_area_r;
  assign out_degenerate     = o_deg_r;
  assign out_overflowed     = o_ovf_r;

  // Product datapath: cross products, cross term, moment terms
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_x_r <= pop_data.x;
      cur_y_r <= pop_data.y;
      le_r    <= pop_data.line_end;
      se_r    <= pop_data.sample_end;
      p1_r    <= prev_x_r * pop_data.y;
      p2_r    <= pop_data.x * prev_y_r;
      sx_r    <= (CW + 1)'(prev_x_r) + (CW + 1)'(pop_data.x);
      sy_r    <= (CW + 1)'(prev_y_r) + (CW + 1)'(pop_data.y);
    end
    if (state_r == S_CROSS) begin
      c_r <= (2 * CW + 1)'(p1_r) - (2 * CW + 1)'(p2_r);
    end
    if (state_r == S_MOM) begin
      tx_r <= tx_full[AW-1:0];
      ty_r <= ty_full[AW-1:0];
    end
  end

  // Sequencer, accumulators and output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ov_r        <= 1'b0;
      have_prev_r <= 1'b0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      area_r      <= '0;
      mx_r        <= '0;
      my_r        <= '0;
      ovf_r       <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (pop) state_r <= S_CROSS;
        end
        S_CROSS: state_r <= S_MOM;
        S_MOM:   state_r <= S_ACC;
        S_ACC: begin
          if (have_prev_r) begin
            area_r <= area_nxt;
            mx_r   <= mx_nxt;
            my_r   <= my_nxt;
            if (ovf_a || ovf_mx || ovf_my) ovf_r <= 1'b1;
          end
          prev_x_r    <= cur_x_r;
          prev_y_r    <= cur_y_r;
          have_prev_r <= !(le_r || se_r);
          o_x_r       <= cur_x_r;
          o_y_r       <= cur_y_r;
          o_cv_r      <= se_r;
          o_cx_r      <= '0;
          o_cy_r      <= '0;
          o_area_r    <= '0;
          o_deg_r     <= 1'b0;
          o_ovf_r     <= 1'b0;
          if (se_r) begin
            state_r <= S_DSET;
          end else begin
            ov_r    <= 1'b1;
            state_r <= S_OUT;
          end
        end
        S_DSET: begin
          // Latch the sample totals, then clear the sums
          o_area_r <= area_r;
          o_ovf_r  <= ovf_r;
          neg_x_r  <= mx_r[AW-1] != area_r[AW-1];
          neg_y_r  <= my_r[AW-1] != area_r[AW-1];
          area_r   <= '0;
          mx_r     <= '0;
          my_r     <= '0;
          ovf_r    <= 1'b0;
          if (area_r == '0) begin
            o_deg_r <= 1'b1;
            ov_r    <= 1'b1;
            state_r <= S_OUT;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (!busy_x && !busy_y) begin
            o_cx_r  <= neg_x_r ? AW'(-q_x) : q_x;
            o_cy_r  <= neg_y_r ? AW'(-q_y) : q_y;
            ov_r    <= 1'b1;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            ov_r    <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
